@@ design/bocol_pkg.sv @@
// shared constants and types for the box collision table
`timescale 1ns / 1ps

package bocol_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;

    // fixed widths of the port fields
    localparam int FIELD_BITS     = 16;
    localparam int VOL_BITS       = 56;
    localparam int CFG_ADDR_BITS  = 5;
    localparam int CFG_DATA_BITS  = 32;
    localparam int NUM_AXES       = 3;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] REG_X_LOW  = 3'd0;
    localparam logic [2:0] REG_X_HIGH = 3'd1;
    localparam logic [2:0] REG_Y_LOW  = 3'd2;
    localparam logic [2:0] REG_Y_HIGH = 3'd3;
    localparam logic [2:0] REG_Z_LOW  = 3'd4;
    localparam logic [2:0] REG_Z_HIGH = 3'd5;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef struct packed {
        logic [NUM_AXES-1:0][FIELD_BITS-1:0] lo;
        logic [NUM_AXES-1:0][FIELD_BITS-1:0] hi;
    } bounds_t;

endpackage

@@ design/bocol_cfg.sv @@
// apb register file holding the bounds of the valid space
`timescale 1ns / 1ps

module bocol_cfg
    import bocol_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output bounds_t                  bounds
);

    bounds_t     bounds_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic [FIELD_BITS-1:0] wval;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign wval    = pwdata[FIELD_BITS-1:0];
    assign bounds  = bounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.lo <= '0;
            bounds_reg.hi <= '1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_X_LOW:  bounds_reg.lo[AXIS_X] <= wval;
                REG_X_HIGH: bounds_reg.hi[AXIS_X] <= wval;
                REG_Y_LOW:  bounds_reg.lo[AXIS_Y] <= wval;
                REG_Y_HIGH: bounds_reg.hi[AXIS_Y] <= wval;
                REG_Z_LOW:  bounds_reg.lo[AXIS_Z] <= wval;
                REG_Z_HIGH: bounds_reg.hi[AXIS_Z] <= wval;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_X_LOW:  prdata = CFG_DATA_BITS'(bounds_reg.lo[AXIS_X]);
            REG_X_HIGH: prdata = CFG_DATA_BITS'(bounds_reg.hi[AXIS_X]);
            REG_Y_LOW:  prdata = CFG_DATA_BITS'(bounds_reg.lo[AXIS_Y]);
            REG_Y_HIGH: prdata = CFG_DATA_BITS'(bounds_reg.hi[AXIS_Y]);
            REG_Z_LOW:  prdata = CFG_DATA_BITS'(bounds_reg.lo[AXIS_Z]);
            REG_Z_HIGH: prdata = CFG_DATA_BITS'(bounds_reg.hi[AXIS_Z]);
            default:    prdata = '0;
        endcase
    end

endmodule

@@ design/bocol_store.sv @@
// synchronous box memory, one write and one registered read port
`timescale 1ns / 1ps

module bocol_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 96
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

@@ design/bocol_vol.sv @@
// two-stage volume multiplier with saturating running total
`timescale 1ns / 1ps

module bocol_vol
    import bocol_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                clear,
    input  logic [CW-1:0]       wx,
    input  logic [CW-1:0]       wy,
    input  logic [CW-1:0]       wz,
    output logic                done,
    output logic [VOL_BITS-1:0] total
);

    logic [2*CW-1:0]     p1_reg;
    logic [3*CW-1:0]     p2_reg;
    logic [CW-1:0]       wz_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic [VOL_BITS-1:0] total_reg;
    logic [VOL_BITS:0]   sum;

    // product is at most 48 bits, so only the sum can overflow
    assign sum   = {1'b0, total_reg} + (VOL_BITS+1)'(p2_reg);
    assign done  = v2_reg;
    assign total = total_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p1_reg <= wx * wy;
            wz_reg <= wz;
        end
        if (v1_reg)
        begin
            p2_reg <= p1_reg * wz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            v1_reg <= load;
            v2_reg <= v1_reg;
            if (clear)
            begin
                total_reg <= '0;
            end
            else if (v2_reg)
            begin
                total_reg <= sum[VOL_BITS] ? '1 : sum[VOL_BITS-1:0];
            end
        end
    end

endmodule

@@ design/box_obstacle_collision_table.sv @@
// box collision table top level: control sequencer, memory, volume unit, registers
//
//  channel   | signals                                      | transfer
//  ----------+----------------------------------------------+---------------------------
//  command   | start, busy, mode, coord_*, width_*          | start high while busy low
//  result    | done, point_free, table_full, stored_boxes,  | one cycle while done high
//            | largest_width, occupied_volume               |
//  config    | psel, penable, pwrite, paddr, pwdata, prdata | psel, penable, pwrite, pready
//
// one item at a time; busy is high from the transfer until the result cycle ends
// query: one stored box per cycle through the memory read port, until a hit or the last entry
// add: goes through the two multiplier stages and the accumulate
// clear, refused add, unused mode, query out of bounds or on an empty table: straight to the result
// rst_n clears the count and totals at once; the box memory needs no clearing pass
// the receiver cannot stall: done is high for exactly one cycle per item
`timescale 1ns / 1ps

module box_obstacle_collision_table
    import bocol_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int CNTW = $clog2(MAX_BOXES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               mode,
    input  logic [FIELD_BITS-1:0]    coord_x,
    input  logic [FIELD_BITS-1:0]    coord_y,
    input  logic [FIELD_BITS-1:0]    coord_z,
    input  logic [FIELD_BITS-1:0]    width_x,
    input  logic [FIELD_BITS-1:0]    width_y,
    input  logic [FIELD_BITS-1:0]    width_z,
    output logic                     done,
    output logic                     point_free,
    output logic                     table_full,
    output logic [CNTW-1:0]          stored_boxes,
    output logic [FIELD_BITS-1:0]    largest_width,
    output logic [VOL_BITS-1:0]      occupied_volume,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int CW = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int DW = 6 * CW;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_VOL  = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t          state_reg;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] scan_idx_reg;
    logic [CW-1:0]   max_reg;
    logic [CW-1:0]   px_reg, py_reg, pz_reg;
    logic            free_reg;
    logic            full_reg;

    bounds_t         bounds;
    logic            accept;
    logic            is_full;
    logic            do_add;
    logic            in_bounds;
    logic [CW-1:0]   cx, cy, cz, wx, wy, wz;
    logic [CW-1:0]   max_next;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [DW-1:0]   mem_rdata;
    logic [CW-1:0]   ex_lx, ex_ly, ex_lz, ex_wx, ex_wy, ex_wz;
    logic            hit;
    logic            vol_done;

    assign accept  = start & ~busy;
    assign busy    = (state_reg != ST_IDLE);
    assign is_full = (count_reg >= CNTW'(MAX_BOXES));
    assign do_add  = accept && (mode == MODE_ADD) && !is_full;

    assign cx = coord_x[CW-1:0];
    assign cy = coord_y[CW-1:0];
    assign cz = coord_z[CW-1:0];
    assign wx = width_x[CW-1:0];
    assign wy = width_y[CW-1:0];
    assign wz = width_z[CW-1:0];

    assign in_bounds =
        (FIELD_BITS'(cx) >= bounds.lo[AXIS_X]) && (FIELD_BITS'(cx) <= bounds.hi[AXIS_X]) &&
        (FIELD_BITS'(cy) >= bounds.lo[AXIS_Y]) && (FIELD_BITS'(cy) <= bounds.hi[AXIS_Y]) &&
        (FIELD_BITS'(cz) >= bounds.lo[AXIS_Z]) && (FIELD_BITS'(cz) <= bounds.hi[AXIS_Z]);

    always_comb
    begin
        max_next = max_reg;
        if (wx > max_next)
        begin
            max_next = wx;
        end
        if (wy > max_next)
        begin
            max_next = wy;
        end
        if (wz > max_next)
        begin
            max_next = wz;
        end
    end

    // entry layout: corner x, y, z then widths x, y, z
    assign {ex_lx, ex_ly, ex_lz, ex_wx, ex_wy, ex_wz} = mem_rdata;

    assign hit = (px_reg >= ex_lx) && ((px_reg - ex_lx) <= ex_wx) &&
                 (py_reg >= ex_ly) && ((py_reg - ex_ly) <= ex_wy) &&
                 (pz_reg >= ex_lz) && ((pz_reg - ex_lz) <= ex_wz);

    assign mem_re    = (accept && (mode == MODE_QUERY)) || (state_reg == ST_SCAN);
    assign mem_raddr = (state_reg == ST_SCAN) ? scan_idx_reg[AW-1:0] : '0;

    bocol_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bounds  (bounds)
    );

    bocol_store #(
        .DEPTH (MAX_BOXES),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .clk   (clk),
        .we    (do_add),
        .waddr (count_reg[AW-1:0]),
        .wdata ({cx, cy, cz, wx, wy, wz}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bocol_vol #(
        .CW (CW)
    ) u_vol (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (do_add),
        .clear (accept && (mode == MODE_CLEAR)),
        .wx    (wx),
        .wy    (wy),
        .wz    (wz),
        .done  (vol_done),
        .total (occupied_volume)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= cx;
            py_reg <= cy;
            pz_reg <= cz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            max_reg      <= '0;
            free_reg     <= 1'b0;
            full_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // a query with no stored box answers from the bounds alone
                        free_reg <= (mode == MODE_QUERY) && in_bounds && (count_reg == '0);
                        full_reg <= (mode == MODE_ADD) && is_full;
                        if ((mode == MODE_ADD) && !is_full)
                        begin
                            count_reg <= count_reg + 1'b1;
                            max_reg   <= max_next;
                            state_reg <= ST_VOL;
                        end
                        else if ((mode == MODE_QUERY) && in_bounds && (count_reg != '0))
                        begin
                            // entry 0 is read at this edge
                            scan_idx_reg <= CNTW'(1);
                            state_reg    <= ST_SCAN;
                        end
                        else if (mode == MODE_CLEAR)
                        begin
                            count_reg <= '0;
                            max_reg   <= '0;
                            state_reg <= ST_RESP;
                        end
                        else
                        begin
                            state_reg <= ST_RESP;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // read data belongs to entry scan_idx_reg - 1
                    if (hit)
                    begin
                        free_reg  <= 1'b0;
                        state_reg <= ST_RESP;
                    end
                    else if (scan_idx_reg == count_reg)
                    begin
                        free_reg  <= 1'b1;
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_VOL:
                begin
                    if (vol_done)
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done          = (state_reg == ST_RESP);
    assign point_free    = free_reg;
    assign table_full    = full_reg;
    assign stored_boxes  = count_reg;
    assign largest_width = FIELD_BITS'(max_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_BOXES))
        else $error("box count above table depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((scan_idx_reg <= count_reg) && (scan_idx_reg != '0)))
        else $error("scan index outside stored entries");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_ADD) && is_full) |=> ($stable(count_reg) && table_full))
        else $error("refused add changed the table");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_add |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("add did not advance the box count");

endmodule

@@ dv/box_obstacle_collision_table_tb.sv @@
// self-checking testbench for the box obstacle collision table
`timescale 1ns / 1ps

module box_obstacle_collision_table_tb;
    import bocol_pkg::*;

    localparam int TABLE_DEPTH = MAX_BOXES_DEF;
    localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [VOL_BITS-1:0] VOLUME_CEIL = '1;
    localparam logic [VOL_BITS-1:0] FULL_CUBE = 56'd65535 * 56'd65535 * 56'd65535;
    localparam coord_max = 16'hffff;

    typedef logic [FIELD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [1:0] op;
        coord_t px;
        coord_t py;
        coord_t pz;
        coord_t wx;
        coord_t wy;
        coord_t wz;
    } command_t;

    typedef struct packed {
        logic free;
        logic full;
        logic [CNT_BITS-1:0] count;
        coord_t widest;
        logic [VOL_BITS-1:0] volume;
    } outcome_t;

    typedef struct packed {
        command_t cmd;
        logic typed;
        outcome_t want;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] mode;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    coord_t width_x;
    coord_t width_y;
    coord_t width_z;
    logic done;
    logic point_free;
    logic table_full;
    logic [CNT_BITS-1:0] stored_boxes;
    coord_t largest_width;
    logic [VOL_BITS-1:0] occupied_volume;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic pready;

    // shadow of the table, totals and bounds
    coord_t box_corner [TABLE_DEPTH][NUM_AXES];
    coord_t box_span [TABLE_DEPTH][NUM_AXES];
    int box_total;
    coord_t widest_seen;
    logic [VOL_BITS-1:0] volume_sum;
    coord_t space_min [NUM_AXES];
    coord_t space_max [NUM_AXES];

    outcome_t expected_results[$];
    script_row_t directed_rows[$];

    int unsigned fail_count;
    int unsigned n_commands;
    int unsigned n_queries;
    int unsigned n_free;
    int unsigned n_refused;
    int unsigned n_checked;
    int unsigned n_bound_sets;

    box_obstacle_collision_table dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .width_x         (width_x),
        .width_y         (width_y),
        .width_z         (width_z),
        .done            (done),
        .point_free      (point_free),
        .table_full      (table_full),
        .stored_boxes    (stored_boxes),
        .largest_width   (largest_width),
        .occupied_volume (occupied_volume),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 clk = ~clk;

    // updates the shadow state and returns what the block should answer
    function automatic outcome_t apply_command(command_t c);
        outcome_t r;
        coord_t p [NUM_AXES];
        coord_t w [NUM_AXES];
        logic [127:0] vol;
        logic [127:0] total;
        bit ok;
        bit in_box;
        r = '0;
        p[AXIS_X] = c.px;
        p[AXIS_Y] = c.py;
        p[AXIS_Z] = c.pz;
        w[AXIS_X] = c.wx;
        w[AXIS_Y] = c.wy;
        w[AXIS_Z] = c.wz;
        n_commands++;
        case (c.op)
            MODE_ADD: begin
                if (box_total >= TABLE_DEPTH) begin
                    r.full = 1'b1;
                    n_refused++;
                end else begin
                    for (int ax = 0; ax < NUM_AXES; ax++) begin
                        box_corner[box_total][ax] = p[ax];
                        box_span[box_total][ax] = w[ax];
                        if (w[ax] > widest_seen)
                            widest_seen = w[ax];
                    end
                    box_total++;
                    vol = 128'(w[AXIS_X]) * 128'(w[AXIS_Y]) * 128'(w[AXIS_Z]);
                    if (vol > VOLUME_CEIL)
                        vol = VOLUME_CEIL;
                    total = 128'(volume_sum) + vol;
                    volume_sum = (total > VOLUME_CEIL) ? VOLUME_CEIL : total[VOL_BITS-1:0];
                end
            end
            MODE_QUERY: begin
                ok = 1'b1;
                for (int ax = 0; ax < NUM_AXES; ax++)
                    if (p[ax] < space_min[ax] || p[ax] > space_max[ax])
                        ok = 1'b0;
                for (int i = 0; ok && i < box_total; i++) begin
                    in_box = 1'b1;
                    for (int ax = 0; ax < NUM_AXES; ax++)
                        if (p[ax] < box_corner[i][ax] ||
                            coord_t'(p[ax] - box_corner[i][ax]) > box_span[i][ax])
                            in_box = 1'b0;
                    if (in_box)
                        ok = 1'b0;
                end
                r.free = ok;
                n_queries++;
                if (ok)
                    n_free++;
            end
            MODE_CLEAR: begin
                box_total = 0;
                widest_seen = '0;
                volume_sum = '0;
            end
            default: ;
        endcase
        r.count = CNT_BITS'(box_total);
        r.widest = widest_seen;
        r.volume = volume_sum;
        return r;
    endfunction

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic coord_t random_width();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return '0;
        if (r < 3)
            return coord_max;
        if (r < 15)
            return coord_t'($urandom_range(0, 255));
        return coord_t'($urandom);
    endfunction

    function automatic command_t random_box(bit clustered);
        command_t c;
        c.op = MODE_ADD;
        c.px = clustered ? coord_t'($urandom_range(0, 1023)) : coord_t'($urandom);
        c.py = clustered ? coord_t'($urandom_range(0, 1023)) : coord_t'($urandom);
        c.pz = clustered ? coord_t'($urandom_range(0, 1023)) : coord_t'($urandom);
        c.wx = random_width();
        c.wy = random_width();
        c.wz = random_width();
        return c;
    endfunction

    // query points: mostly on or around a stored box, some on the bounds, some anywhere
    function automatic command_t random_probe();
        command_t c;
        coord_t v [NUM_AXES];
        coord_t lo;
        coord_t wd;
        int b;
        int sel;
        int kind;
        c = random_box(1'b0);
        c.op = MODE_QUERY;
        sel = $urandom_range(0, 9);
        b = (box_total > 0) ? $urandom_range(0, box_total - 1) : -1;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            kind = $urandom_range(0, 9);
            if (b >= 0 && sel < 6) begin
                lo = box_corner[b][ax];
                wd = box_span[b][ax];
                case (kind)
                    6: v[ax] = lo - 1'b1;
                    7: v[ax] = lo;
                    8: v[ax] = lo + wd;
                    9: v[ax] = lo + wd + 1'b1;
                    default: v[ax] = lo + coord_t'($urandom_range(0, wd));
                endcase
            end else if (sel < 8) begin
                case (kind)
                    0, 1: v[ax] = space_min[ax] - 1'b1;
                    2, 3: v[ax] = space_min[ax];
                    4, 5: v[ax] = space_max[ax];
                    6, 7: v[ax] = space_max[ax] + 1'b1;
                    default: v[ax] = coord_t'($urandom_range(0, 1023));
                endcase
            end else begin
                v[ax] = coord_t'($urandom);
            end
        end
        c.px = v[AXIS_X];
        c.py = v[AXIS_Y];
        c.pz = v[AXIS_Z];
        return c;
    endfunction

    function automatic script_row_t row(logic [1:0] op, coord_t x, coord_t y, coord_t z,
                                        coord_t wx, coord_t wy, coord_t wz, logic typed,
                                        logic free, logic full, int count, coord_t widest,
                                        logic [VOL_BITS-1:0] volume);
        script_row_t s;
        s.cmd = '{op, x, y, z, wx, wy, wz};
        s.typed = typed;
        s.want = '{free, full, CNT_BITS'(count), widest, volume};
        return s;
    endfunction

    task automatic add_row(script_row_t s);
        directed_rows = {directed_rows, s};
    endtask

    // called right after a rising edge; returns right after the accepting edge or the gap
    task automatic send_command(command_t c, int gap, logic typed, outcome_t want);
        outcome_t got;
        start <= 1'b1;
        mode <= c.op;
        coord_x <= c.px;
        coord_y <= c.py;
        coord_z <= c.pz;
        width_x <= c.wx;
        width_y <= c.wy;
        width_z <= c.wz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        got = apply_command(c);
        expected_results = {expected_results, typed ? want : got};
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, coord_t value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        // upper bits are junk, the register keeps only the low half
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_X_LOW:  space_min[AXIS_X] = value;
            REG_X_HIGH: space_max[AXIS_X] = value;
            REG_Y_LOW:  space_min[AXIS_Y] = value;
            REG_Y_HIGH: space_max[AXIS_Y] = value;
            REG_Z_LOW:  space_min[AXIS_Z] = value;
            REG_Z_HIGH: space_max[AXIS_Z] = value;
            default: ;
        endcase
        // the bus idles between transfers
        @(posedge clk);
    endtask

    task automatic reg_check(logic [2:0] idx, coord_t want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[FIELD_BITS-1:0] !== want) begin
            $error("prdata: expected %0d, got %0d", want, prdata[FIELD_BITS-1:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_bounds(coord_t xl, coord_t xh, coord_t yl, coord_t yh,
                              coord_t zl, coord_t zh);
        drain_results();
        reg_write(REG_X_LOW, xl);
        reg_write(REG_X_HIGH, xh);
        reg_write(REG_Y_LOW, yl);
        reg_write(REG_Y_HIGH, yh);
        reg_write(REG_Z_LOW, zl);
        reg_write(REG_Z_HIGH, zh);
        reg_check(REG_X_LOW, space_min[AXIS_X]);
        reg_check(REG_X_HIGH, space_max[AXIS_X]);
        reg_check(REG_Y_LOW, space_min[AXIS_Y]);
        reg_check(REG_Y_HIGH, space_max[AXIS_Y]);
        reg_check(REG_Z_LOW, space_min[AXIS_Z]);
        reg_check(REG_Z_HIGH, space_max[AXIS_Z]);
        n_bound_sets++;
    endtask

    // scenes: clear, then add boxes while probing the table, with some unused modes and clears
    task automatic run_scenes(int items);
        command_t c;
        int sent;
        int adds_left;
        int r;
        bit first;
        bit burst;
        bit clustered;
        sent = 0;
        first = 1'b1;
        while (sent < items) begin
            // the first scene of each phase runs past a full table
            adds_left = first ? TABLE_DEPTH + 6 : $urandom_range(1, TABLE_DEPTH + 8);
            first = 1'b0;
            burst = ($urandom_range(0, 3) == 0);
            clustered = ($urandom_range(0, 2) != 0);
            c = random_box(1'b0);
            c.op = MODE_CLEAR;
            send_command(c, pick_gap(burst), 1'b0, '0);
            sent++;
            while (adds_left > 0 && sent < items) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    c = random_box(clustered);
                    adds_left--;
                end else if (r < 94) begin
                    c = random_probe();
                end else if (r < 97) begin
                    c = random_box(1'b0);
                    c.op = MODE_UNUSED;
                end else begin
                    c = random_box(1'b0);
                    c.op = MODE_CLEAR;
                end
                send_command(c, pick_gap(burst), 1'b0, '0);
                if (c.op != MODE_UNUSED)
                    sent++;
            end
        end
    endtask

    always @(posedge clk) begin : result_check
        outcome_t want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing pending");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (point_free !== want.free) begin
                    $error("point_free: expected %0d, got %0d", want.free, point_free);
                    fail_count++;
                end
                if (table_full !== want.full) begin
                    $error("table_full: expected %0d, got %0d", want.full, table_full);
                    fail_count++;
                end
                if (stored_boxes !== want.count) begin
                    $error("stored_boxes: expected %0d, got %0d", want.count, stored_boxes);
                    fail_count++;
                end
                if (largest_width !== want.widest) begin
                    $error("largest_width: expected %0d, got %0d", want.widest, largest_width);
                    fail_count++;
                end
                if (occupied_volume !== want.volume) begin
                    $error("occupied_volume: expected %0d, got %0d", want.volume,
                           occupied_volume);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_ADD;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        width_x = '0;
        width_y = '0;
        width_z = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        n_commands = 0;
        n_queries = 0;
        n_free = 0;
        n_refused = 0;
        n_checked = 0;
        n_bound_sets = 0;
        box_total = 0;
        widest_seen = '0;
        volume_sum = '0;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            space_min[ax] = '0;
            space_max[ax] = coord_max;
        end

        // reset values of bounds and totals, box edges inclusive, zero-size and
        // maximal boxes, unused mode, clear
        add_row(row(MODE_QUERY, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        add_row(row(MODE_QUERY, coord_max, coord_max, coord_max,
                    coord_max, coord_max, coord_max, 1, 1, 0, 0, 0, 0));
        add_row(row(MODE_UNUSED, 5, 6, 7, 8, 9, 10, 1, 0, 0, 0, 0, 0));
        add_row(row(MODE_ADD, 100, 200, 300, 10, 20, 30, 1, 0, 0, 1, 30, 6000));
        add_row(row(MODE_QUERY, 100, 200, 300, 0, 0, 0, 1, 0, 0, 1, 30, 6000));
        add_row(row(MODE_QUERY, 110, 220, 330, 0, 0, 0, 1, 0, 0, 1, 30, 6000));
        add_row(row(MODE_QUERY, 111, 220, 330, 0, 0, 0, 1, 1, 0, 1, 30, 6000));
        add_row(row(MODE_QUERY, 99, 200, 300, 0, 0, 0, 1, 1, 0, 1, 30, 6000));
        add_row(row(MODE_ADD, 0, 0, 0, 0, 0, 0, 1, 0, 0, 2, 30, 6000));
        add_row(row(MODE_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 0, 2, 30, 6000));
        add_row(row(MODE_QUERY, 0, 0, 1, 0, 0, 0, 1, 1, 0, 2, 30, 6000));
        add_row(row(MODE_ADD, coord_max, coord_max, coord_max, coord_max,
                    coord_max, coord_max, 1, 0, 0, 3, coord_max,
                    FULL_CUBE + 56'd6000));
        add_row(row(MODE_QUERY, coord_max, coord_max, coord_max, 0, 0, 0,
                    1, 0, 0, 3, coord_max, FULL_CUBE + 56'd6000));
        add_row(row(MODE_QUERY, 16'hfffe, coord_max, coord_max, 0, 0, 0,
                    1, 1, 0, 3, coord_max, FULL_CUBE + 56'd6000));
        add_row(row(MODE_UNUSED, 1, 2, 3, 4, 5, 6, 1, 0, 0, 3, coord_max,
                    FULL_CUBE + 56'd6000));
        add_row(row(MODE_CLEAR, 100, 200, 300, 1, 1, 1, 1, 0, 0, 0, 0, 0));
        add_row(row(MODE_QUERY, 100, 200, 300, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        add_row(row(MODE_ADD, 40000, 40000, 40000, 1, coord_max, 0,
                    0, 0, 0, 0, 0, 0));
        add_row(row(MODE_ADD, 30000, 50, 7, 65000, 3, 9000, 0, 0, 0, 0, 0, 0));
        add_row(row(MODE_QUERY, 40001, 50000, 40000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(MODE_QUERY, 40000, 40000, 40001, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(MODE_QUERY, 41000, 52, 9007, coord_max, coord_max,
                    coord_max, 0, 0, 0, 0, 0, 0));
        add_row(row(MODE_QUERY, 41000, 54, 9007, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, pick_gap(1'b0), directed_rows[i].typed,
                         directed_rows[i].want);

        // whole space
        set_bounds(0, coord_max, 0, coord_max, 0, coord_max);
        run_scenes(400);

        // random window over the crowded corner of the space
        set_bounds(coord_t'($urandom_range(0, 300)), coord_t'($urandom_range(600, 2000)),
                   coord_t'($urandom_range(0, 300)), coord_t'($urandom_range(600, 2000)),
                   coord_t'($urandom_range(0, 300)), coord_t'($urandom_range(600, 2000)));
        run_scenes(400);

        // low above high on one axis: nothing can be free
        set_bounds(0, 900, 5000, 4999, 0, coord_max);
        run_scenes(350);

        // single-point bounds at both ends of the range and inside the crowded corner
        set_bounds(0, 0, coord_max, coord_max, 512, 512);
        run_scenes(300);

        set_bounds(100, 900, 0, 1023, 200, 700);
        run_scenes(500);

        drain_results();
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("summary: %0d commands, %0d queries (%0d free), %0d adds refused, %0d bound sets",
                 n_commands, n_queries, n_free, n_refused, n_bound_sets);
        $display("summary: %0d results compared, %0d mismatches", n_checked, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/bocol_pkg.sv
design/bocol_cfg.sv
design/bocol_store.sv
design/bocol_vol.sv
design/box_obstacle_collision_table.sv
dv/box_obstacle_collision_table_tb.sv
